FILE: design/pf2d_pkg.sv
// ----------------------------------------------------------------------------
// pf2d_pkg: shared types and codes for the two-cost Pareto front filter
// Holds the operation codes, the payload layouts of the input and result
// words, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pf2d_pkg;

    // Fixed widths of the external payload fields.
    localparam int OP_BITS    = 2;
    localparam int PT_BITS    = 32;
    localparam int CNT_BITS   = 7;

    // Operation codes carried in the input word.
    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

    // One input word.
    typedef struct packed {
        logic [OP_BITS-1:0] operation;
        logic [PT_BITS-1:0] point_time;
        logic [PT_BITS-1:0] point_length;
    } t_pf2d_in;

    // One result word.
    typedef struct packed {
        logic                dominated;
        logic                inserted;
        logic [CNT_BITS-1:0] removed_count;
        logic [CNT_BITS-1:0] entry_count;
        logic                overflow;
    } t_pf2d_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_pf2d_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } t_pf2d_sts;

endpackage

FILE: design/pf2d_in_if.sv
// ----------------------------------------------------------------------------
// pf2d_in_if: input channel of the Pareto front filter
// Valid/ready channel that moves one input word per handshake.
// ----------------------------------------------------------------------------
interface pf2d_in_if;
    import pf2d_pkg::*;

    logic     valid;
    logic     ready;
    t_pf2d_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pf2d_out_if.sv
// ----------------------------------------------------------------------------
// pf2d_out_if: result channel of the Pareto front filter
// Valid/ready channel that moves one result word per handshake.
// ----------------------------------------------------------------------------
interface pf2d_out_if;
    import pf2d_pkg::*;

    logic      valid;
    logic      ready;
    t_pf2d_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pf2d_ram.sv
// ----------------------------------------------------------------------------
// pf2d_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pf2d_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pf2d_ctrl.sv
// ----------------------------------------------------------------------------
// pf2d_ctrl: controller of the Pareto front filter
// Sequences one word at a time through load, scan and commit, and owns the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module pf2d_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pf2d_pkg::t_pf2d_cmd   o_cmd,
    input  pf2d_pkg::t_pf2d_sts   i_sts
);
    import pf2d_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // The result register can take a new word once the old one is gone.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Commands to the datapath.
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = i_in_valid && (r_state == S_IDLE);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_DONE) && out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result valid flag: set on commit, cleared once the word is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A finished word waits in the done state while the result register is held.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("done state left while the result register was full");

    // A commit always leaves a valid word in the result register.
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("commit did not present a result word");

endmodule

FILE: design/pf2d_dp.sv
// ----------------------------------------------------------------------------
// pf2d_dp: datapath of the Pareto front filter
// Holds the front packed at the low addresses of a RAM and sweeps it once per
// query or insert: it checks dominance and compacts away the points that an
// insert dominates, appending it at commit if undominated and room remains.
// ----------------------------------------------------------------------------
module pf2d_dp #(
    parameter int FRONT_DEPTH = 64,
    parameter int COST_BITS   = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pf2d_pkg::t_pf2d_in    i_data,
    output pf2d_pkg::t_pf2d_out   o_data,
    input  pf2d_pkg::t_pf2d_cmd   i_cmd,
    output pf2d_pkg::t_pf2d_sts   o_sts
);
    import pf2d_pkg::*;

    localparam int AW = $clog2(FRONT_DEPTH);
    localparam int CW = $clog2(FRONT_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(FRONT_DEPTH);

    logic [OP_BITS-1:0]     r_op;
    logic [COST_BITS-1:0]   r_t;
    logic [COST_BITS-1:0]   r_l;
    logic [CW-1:0]          r_rd;
    logic [CW-1:0]          r_wr;
    logic [CW-1:0]          r_drop;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_dv;
    logic                   r_dom;
    t_pf2d_out              r_res;
    t_pf2d_out              n_res;

    logic                   is_insert;
    logic                   needs_scan;
    logic                   issue;
    logic [2*COST_BITS-1:0] rdata;
    logic [COST_BITS-1:0]   e_t;
    logic [COST_BITS-1:0]   e_l;
    logic                   hit;
    logic                   drop;
    logic                   keep_wr;
    logic                   do_ins;
    logic                   ovf;
    logic                   ram_we;
    logic [2*COST_BITS-1:0] ram_wdata;

    assign is_insert  = (r_op == OP_INSERT);
    assign needs_scan = (r_op == OP_QUERY) || is_insert;

    // Sweep: one read issued per cycle, compared in the cycle after.
    assign issue = i_cmd.scan && needs_scan && (r_rd != r_count);
    assign e_t   = rdata[2*COST_BITS-1:COST_BITS];
    assign e_l   = rdata[COST_BITS-1:0];
    assign hit   = r_dv && (e_t <= r_t) && (e_l <= r_l);
    // A stored point equal to the new one dominates it, so it is kept.
    assign drop  = r_dv && is_insert && !hit && (r_t <= e_t) && (r_l <= e_l);

    // Points that survive an insert are moved down to close the gaps.
    assign keep_wr = r_dv && is_insert && !drop;

    assign o_sts.scan_done = !needs_scan || ((r_rd == r_count) && !r_dv);

    // Commit decisions for an insert.
    assign ovf    = is_insert && !r_dom && (r_wr == FULL);
    assign do_ins = is_insert && !r_dom && (r_wr != FULL);

    assign ram_we    = keep_wr || (i_cmd.commit && do_ins);
    assign ram_wdata = keep_wr ? rdata : {r_t, r_l};

    pf2d_ram #(
        .WIDTH (2 * COST_BITS),
        .DEPTH (FRONT_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (rdata)
    );

    // Point count after the word, and the result word.
    always_comb begin
        n_count = r_count;
        if (r_op == OP_CLEAR) begin
            n_count = '0;
        end else if (do_ins) begin
            n_count = r_wr + CW'(1);
        end
        n_res               = '0;
        n_res.dominated     = needs_scan && r_dom;
        n_res.inserted      = do_ins;
        n_res.removed_count = do_ins ? CNT_BITS'(r_drop) : '0;
        n_res.entry_count   = CNT_BITS'(n_count);
        n_res.overflow      = ovf;
    end

    // Control state: count and the read pipeline flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
            r_dv <= issue;
        end
    end

    // Word registers and sweep counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_data.operation;
            r_t    <= COST_BITS'(i_data.point_time);
            r_l    <= COST_BITS'(i_data.point_length);
            r_rd   <= '0;
            r_wr   <= '0;
            r_drop <= '0;
            r_dom  <= 1'b0;
        end else begin
            if (issue) begin
                r_rd <= r_rd + CW'(1);
            end
            if (keep_wr) begin
                r_wr <= r_wr + CW'(1);
            end
            if (drop) begin
                r_drop <= r_drop + CW'(1);
            end
            if (hit) begin
                r_dom <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
    end

    assign o_data = r_res;

    // The front never holds more points than the RAM has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("point count beyond the front depth");

    // Compaction only writes at or below the entry whose data is being compared.
    a_compact_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        keep_wr |-> (r_wr < r_rd))
        else $error("compaction write overtook the read sweep");

    // An accepted insert grows the front by one over the survivors.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && do_ins) |=> (r_count == $past(r_wr) + CW'(1)))
        else $error("point count wrong after an insert");

endmodule

FILE: design/pareto_front_2d_filter.sv
// ----------------------------------------------------------------------------
// pareto_front_2d_filter: bounded two-cost Pareto front
// Answers dominance queries, inserts points while dropping those they
// dominate, and clears the front; one result word per input word.
//
//   Channel   Direction   Word
//   i_in      sink        operation, point_time, point_length
//   o_out     source      dominated, inserted, removed_count, entry_count,
//                         overflow
//
// A query or insert sweeps the front once through the single read port of its
// RAM, one point per cycle; a clear, an unused code or an empty front reads no
// point. One word is in work at a time; the next word is accepted in the
// cycle after the previous result is loaded, even while that result still
// waits. A held result delays the commit of the next result. Reset empties
// the front at once.
// ----------------------------------------------------------------------------
module pareto_front_2d_filter #(
    parameter int FRONT_DEPTH = 64,
    parameter int COST_BITS   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pf2d_in_if.sink         i_in,
    pf2d_out_if.source      o_out
);
    import pf2d_pkg::*;

    t_pf2d_cmd cmd;
    t_pf2d_sts sts;

    // Sequencing of load, sweep and commit.
    pf2d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Front storage, compare logic and result register.
    pf2d_dp #(
        .FRONT_DEPTH (FRONT_DEPTH),
        .COST_BITS   (COST_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_in.data),
        .o_data  (o_out.data),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
